// ===== src/nand_command_sequencer_defines.svh =====
// ---------------------------------------------------------------------------
// NAND command sequencer assertion macros
// Concurrent check macros used by the sequencer controller.
// ---------------------------------------------------------------------------
`ifndef NAND_COMMAND_SEQUENCER_DEFINES_SVH
`define NAND_COMMAND_SEQUENCER_DEFINES_SVH

`ifndef SYNTH

// Check clocked on i_clk and disabled while i_rst_n is low.
`define NSQ_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("nand command sequencer check failed");

// Check clocked on i_clk that also holds during reset.
`define NSQ_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("nand command sequencer check failed");

`else

`define NSQ_ASSERT(lbl, prop)
`define NSQ_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== src/nsq_pkg.sv =====
// ---------------------------------------------------------------------------
// NAND command sequencer package
// Field widths, operation and cycle codes, NAND command bytes and the
// control and status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package nsq_pkg;

    localparam int OP_W    = 3;
    localparam int ADDR_W  = 29;
    localparam int LEN_W   = 12;
    localparam int SPARE_W = 8;
    localparam int KIND_W  = 3;
    localparam int BYTE_W  = 8;
    localparam int STEP_W  = 4;

    localparam int BLOCK_COUNT = 2048;
    localparam int PAGE_BYTES  = 2112;
    localparam int BLK_LSB     = 18;
    localparam int BLK_W       = ADDR_W - BLK_LSB;
    localparam int BLK_AW      = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;

    localparam int ID_BYTES = 5;
    // Longest sequence is a page program: eleven bus cycles.
    localparam int MAX_STEP = 10;

    localparam logic [BYTE_W-1:0] CMD_READ_SETUP = 8'h00;
    localparam logic [BYTE_W-1:0] CMD_READ_START = 8'h30;
    localparam logic [BYTE_W-1:0] CMD_PROG_SETUP = 8'h80;
    localparam logic [BYTE_W-1:0] CMD_PROG_START = 8'h10;
    localparam logic [BYTE_W-1:0] CMD_ERASE_SETUP = 8'h60;
    localparam logic [BYTE_W-1:0] CMD_ERASE_START = 8'hd0;
    localparam logic [BYTE_W-1:0] CMD_READ_ID    = 8'h90;
    localparam logic [BYTE_W-1:0] CMD_RESET      = 8'hff;
    localparam logic [SPARE_W-1:0] SPARE_GOOD    = 8'hff;

    typedef enum logic [OP_W-1:0] {
        OP_READ    = 3'd0,
        OP_PROGRAM = 3'd1,
        OP_ERASE   = 3'd2,
        OP_READ_ID = 3'd3,
        OP_RESET   = 3'd4,
        OP_RECORD  = 3'd5
    } t_op;

    typedef enum logic [KIND_W-1:0] {
        KIND_CMD     = 3'd0,
        KIND_ADDR    = 3'd1,
        KIND_WAIT    = 3'd2,
        KIND_DATA    = 3'd3,
        KIND_STATUS  = 3'd4,
        KIND_REFUSED = 3'd5,
        KIND_TABLE   = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic              load_req;
        logic              clear_step;
        logic              emit;
        logic [STEP_W-1:0] step;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_last;
        logic out_free;
        logic seq_last;
    } t_dp_status;

endpackage

// ===== src/nsq_if.sv =====
// ---------------------------------------------------------------------------
// NAND command sequencer channels
// Request and result channels with valid/ready handshakes.
// ---------------------------------------------------------------------------
interface nsq_req_if;
    import nsq_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [ADDR_W-1:0]  flash_address;
    logic [LEN_W-1:0]   transfer_length;
    logic [SPARE_W-1:0] spare_first;
    logic [SPARE_W-1:0] spare_second;

    modport source(output valid, op, flash_address, transfer_length, spare_first,
                   spare_second, input ready);
    modport sink(input valid, op, flash_address, transfer_length, spare_first,
                 spare_second, output ready);
endinterface

interface nsq_res_if;
    import nsq_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] cycle_kind;
    logic [BYTE_W-1:0] bus_byte;
    logic [LEN_W-1:0]  phase_length;
    logic              last;

    modport source(output valid, cycle_kind, bus_byte, phase_length, last, input ready);
    modport sink(input valid, cycle_kind, bus_byte, phase_length, last, output ready);
endinterface

// ===== src/nsq_datapath.sv =====
// ---------------------------------------------------------------------------
// NAND command sequencer datapath
// Request registers, bad-block table memory, bus cycle decoder and the
// result output register.
// ---------------------------------------------------------------------------
module nsq_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nsq_pkg::t_dp_cmd              i_cmd,
    output nsq_pkg::t_dp_status           o_status,
    input  logic [nsq_pkg::OP_W-1:0]      i_op,
    input  logic [nsq_pkg::ADDR_W-1:0]    i_flash_address,
    input  logic [nsq_pkg::LEN_W-1:0]     i_transfer_length,
    input  logic [nsq_pkg::SPARE_W-1:0]   i_spare_first,
    input  logic [nsq_pkg::SPARE_W-1:0]   i_spare_second,
    input  logic                          i_res_ready,
    output logic                          o_res_valid,
    output logic [nsq_pkg::KIND_W-1:0]    o_cycle_kind,
    output logic [nsq_pkg::BYTE_W-1:0]    o_bus_byte,
    output logic [nsq_pkg::LEN_W-1:0]     o_phase_length,
    output logic                          o_last
);
    import nsq_pkg::*;

    logic              r_table [BLOCK_COUNT];
    logic              r_rd;
    logic [BLK_AW-1:0] r_clear_addr;

    logic [OP_W-1:0]   r_op;
    logic [ADDR_W-1:0] r_addr;
    logic [LEN_W-1:0]  r_len;
    logic              r_mark;
    logic              r_in_range;

    logic              r_out_valid;
    t_kind             r_out_kind;
    logic [BYTE_W-1:0] r_out_byte;
    logic [LEN_W-1:0]  r_out_len;
    logic              r_out_last;

    logic [BLK_W-1:0]  w_in_blk;
    logic [BLK_W-1:0]  w_blk;
    logic              w_we;
    logic [BLK_AW-1:0] w_wa;
    logic              w_bad;
    logic              w_rec_write;
    t_kind             w_kind;
    logic [BYTE_W-1:0] w_byte;
    logic [LEN_W-1:0]  w_len;
    logic              w_last;
    logic [STEP_W-1:0] w_addr_idx;

    function automatic logic [BYTE_W-1:0] addr_byte(input logic [ADDR_W-1:0] a,
                                                     input logic [2:0] k);
        logic [BYTE_W-1:0] b;
        case (k)
            3'd0:    b = a[7:0];
            3'd1:    b = {4'b0000, a[11:8]};
            3'd2:    b = a[19:12];
            3'd3:    b = a[27:20];
            default: b = {7'b0000000, a[28]};
        endcase
        return b;
    endfunction

    assign w_in_blk = i_flash_address[ADDR_W-1:BLK_LSB];
    assign w_blk    = r_addr[ADDR_W-1:BLK_LSB];

    // Request capture; the length saturates to one page with spare.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op       <= i_op;
            r_addr     <= i_flash_address;
            r_len      <= (i_transfer_length > LEN_W'(PAGE_BYTES)) ?
                          LEN_W'(PAGE_BYTES) : i_transfer_length;
            r_mark     <= (i_spare_first != SPARE_GOOD) || (i_spare_second != SPARE_GOOD);
            r_in_range <= ({1'b0, w_in_blk} < (BLK_W + 1)'(BLOCK_COUNT));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_addr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clear_addr <= r_clear_addr + 1'b1;
        end
    end

    assign w_rec_write = i_cmd.emit && (r_op == OP_RECORD) && r_in_range && r_mark;
    assign w_we        = i_cmd.clear_step || w_rec_write;
    assign w_wa        = i_cmd.clear_step ? r_clear_addr : w_blk[BLK_AW-1:0];

    // The table is read once per request, at the transfer of the request.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_table[w_wa] <= !i_cmd.clear_step;
        end
        if (i_cmd.load_req) begin
            r_rd <= r_table[w_in_blk[BLK_AW-1:0]];
        end
    end

    assign w_bad      = !r_in_range || r_rd;
    assign w_addr_idx = i_cmd.step - STEP_W'(2);

    always_comb begin
        w_kind = KIND_REFUSED;
        w_byte = '0;
        w_len  = '0;
        w_last = 1'b1;
        unique case (r_op)
            OP_READ: begin
                if (!w_bad) begin
                    w_last = 1'b0;
                    unique case (i_cmd.step)
                        4'd0: w_kind = KIND_WAIT;
                        4'd1: begin
                            w_kind = KIND_CMD;
                            w_byte = CMD_READ_SETUP;
                        end
                        4'd2, 4'd3, 4'd4, 4'd5, 4'd6: begin
                            w_kind = KIND_ADDR;
                            w_byte = addr_byte(r_addr, w_addr_idx[2:0]);
                        end
                        4'd7: begin
                            w_kind = KIND_CMD;
                            w_byte = CMD_READ_START;
                        end
                        4'd8: w_kind = KIND_WAIT;
                        default: begin
                            w_kind = KIND_DATA;
                            w_len  = r_len;
                            w_last = 1'b1;
                        end
                    endcase
                end
            end
            OP_PROGRAM: begin
                if (!w_bad) begin
                    w_last = 1'b0;
                    unique case (i_cmd.step)
                        4'd0: w_kind = KIND_WAIT;
                        4'd1: begin
                            w_kind = KIND_CMD;
                            w_byte = CMD_PROG_SETUP;
                        end
                        4'd2, 4'd3, 4'd4, 4'd5, 4'd6: begin
                            w_kind = KIND_ADDR;
                            w_byte = addr_byte(r_addr, w_addr_idx[2:0]);
                        end
                        4'd7: begin
                            w_kind = KIND_DATA;
                            w_len  = r_len;
                        end
                        4'd8: begin
                            w_kind = KIND_CMD;
                            w_byte = CMD_PROG_START;
                        end
                        4'd9: w_kind = KIND_WAIT;
                        default: begin
                            w_kind = KIND_STATUS;
                            w_last = 1'b1;
                        end
                    endcase
                end
            end
            OP_ERASE: begin
                if (!w_bad) begin
                    w_last = 1'b0;
                    unique case (i_cmd.step)
                        4'd0: w_kind = KIND_WAIT;
                        4'd1: begin
                            w_kind = KIND_CMD;
                            w_byte = CMD_ERASE_SETUP;
                        end
                        // Row bytes only: the step number is the address byte index.
                        4'd2, 4'd3, 4'd4: begin
                            w_kind = KIND_ADDR;
                            w_byte = addr_byte(r_addr, i_cmd.step[2:0]);
                        end
                        4'd5: begin
                            w_kind = KIND_CMD;
                            w_byte = CMD_ERASE_START;
                        end
                        4'd6: w_kind = KIND_WAIT;
                        default: begin
                            w_kind = KIND_STATUS;
                            w_last = 1'b1;
                        end
                    endcase
                end
            end
            OP_READ_ID: begin
                w_last = 1'b0;
                unique case (i_cmd.step)
                    4'd0: w_kind = KIND_WAIT;
                    4'd1: begin
                        w_kind = KIND_CMD;
                        w_byte = CMD_READ_ID;
                    end
                    4'd2: w_kind = KIND_ADDR;
                    default: begin
                        w_kind = KIND_DATA;
                        w_len  = LEN_W'(ID_BYTES);
                        w_last = 1'b1;
                    end
                endcase
            end
            OP_RESET: begin
                if (i_cmd.step == 4'd0) begin
                    w_kind = KIND_CMD;
                    w_byte = CMD_RESET;
                    w_last = 1'b0;
                end else begin
                    w_kind = KIND_WAIT;
                end
            end
            OP_RECORD: begin
                w_kind = KIND_TABLE;
                w_byte = {7'b0000000, r_in_range && (r_rd || r_mark)};
            end
            default: begin
                w_kind = KIND_REFUSED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_kind <= w_kind;
            r_out_byte <= w_byte;
            r_out_len  <= w_len;
            r_out_last <= w_last;
        end
    end

    assign o_status.clear_last = (r_clear_addr == BLK_AW'(BLOCK_COUNT - 1));
    assign o_status.out_free   = !r_out_valid || i_res_ready;
    assign o_status.seq_last   = w_last;

    assign o_res_valid    = r_out_valid;
    assign o_cycle_kind   = r_out_kind;
    assign o_bus_byte     = r_out_byte;
    assign o_phase_length = r_out_len;
    assign o_last         = r_out_last;

endmodule

// ===== src/nsq_controller.sv =====
// ---------------------------------------------------------------------------
// NAND command sequencer controller
// Sequences the table clearing pass, request transfers and the stepping
// through bus cycles of the current request.
// ---------------------------------------------------------------------------
`include "nand_command_sequencer_defines.svh"

module nsq_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    output logic                o_req_ready,
    output nsq_pkg::t_dp_cmd    o_cmd,
    input  nsq_pkg::t_dp_status i_status
);
    import nsq_pkg::*;

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    logic              w_accept;

    assign w_accept = i_req_valid && o_req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free && i_status.seq_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_req_ready      = 1'b0;
        o_cmd.load_req   = 1'b0;
        o_cmd.clear_step = 1'b0;
        o_cmd.emit       = 1'b0;
        o_cmd.step       = r_step;
        n_step           = r_step;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
            end
            S_IDLE: begin
                o_req_ready    = 1'b1;
                o_cmd.load_req = w_accept;
                n_step         = '0;
            end
            S_EMIT: begin
                o_cmd.emit = i_status.out_free;
                if (i_status.out_free) begin
                    n_step = r_step + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    `NSQ_ASSERT(a_accept_starts_emit, w_accept |=> (r_state == S_EMIT) && (r_step == '0))
    `NSQ_ASSERT(a_emit_needs_room, o_cmd.emit |-> i_status.out_free)
    `NSQ_ASSERT(a_last_ends_request, (o_cmd.emit && i_status.seq_last) |=> (r_state == S_IDLE))
    `NSQ_ASSERT_ALWAYS(a_step_bounded, (r_state == S_EMIT) |-> (r_step <= STEP_W'(MAX_STEP)))

endmodule

// ===== src/nand_command_sequencer.sv =====
// ---------------------------------------------------------------------------
// NAND command sequencer
// Large-page NAND flash bus cycle sequencer with a sticky bad-block table.
// ---------------------------------------------------------------------------
// After reset the block first clears all BLOCK_COUNT (2048) entries of its
// bad-block table, one entry per clock; no request is taken before that
// pass ends. A request's bus cycle results then follow one per clock from
// the output register while the result channel does not stall it. The
// controller steps through one bus cycle per clock while the output
// register is free and takes a new request only after the last result is
// issued; the table is read once at the request transfer and written on a
// record only for an in-range block whose spare bytes are not both 8'hff.
// ---------------------------------------------------------------------------
module nand_command_sequencer (
    input  logic      i_clk,
    input  logic      i_rst_n,
    nsq_req_if.sink   i_req,
    nsq_res_if.source o_res
);
    import nsq_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    nsq_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    nsq_datapath u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_status          (w_status),
        .i_op              (i_req.op),
        .i_flash_address   (i_req.flash_address),
        .i_transfer_length (i_req.transfer_length),
        .i_spare_first     (i_req.spare_first),
        .i_spare_second    (i_req.spare_second),
        .i_res_ready       (o_res.ready),
        .o_res_valid       (o_res.valid),
        .o_cycle_kind      (o_res.cycle_kind),
        .o_bus_byte        (o_res.bus_byte),
        .o_phase_length    (o_res.phase_length),
        .o_last            (o_res.last)
    );

endmodule
